// ===== design/pci_config_access_port_unit_defines.svh =====
// Assertion helpers for the checker file.
`ifndef PCI_CONFIG_ACCESS_PORT_UNIT_DEFINES_SVH
`define PCI_CONFIG_ACCESS_PORT_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define PCICFG_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcicfg: implication check failed");

// next-cycle implication
`define PCICFG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcicfg: next-cycle check failed");

`endif

// ===== design/pcicfg_pkg.sv =====
package pcicfg_pkg;

    localparam logic       OP_READ  = 1'b0;
    localparam logic       OP_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_WORD  = 2'd1;
    localparam logic [1:0] SIZE_DWORD = 2'd2;

    localparam logic       CFG_BUS_NUMBER   = 1'b0;
    localparam logic       CFG_DEVICE_COUNT = 1'b1;

    // upper byte of the 0x8000 enable/tag field in index bits 31:16
    localparam logic [7:0] HOST_TAG = 8'h80;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_DIRECT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_WRITE  = 2'd3;

    localparam int NUM_BANKS = 4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [31:0]      data;     // direct result or write data
        logic [4:0]       dev;
        logic [3:0][5:0]  row;      // per byte bank
        logic [3:0]       bank_en;
        logic [1:0]       rot;      // bank of result byte 0
        logic [3:0]       keep;     // result bytes covered by the size
        logic [3:0]       ff;       // result bytes beyond the store
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

// ===== design/pcicfg_front.sv =====
module pcicfg_front #(
    parameter int MAX_DEVICES  = 32,
    parameter int CONFIG_BYTES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [1:0]                access_size,
    input  logic [2:0]                port_offset,
    input  logic [31:0]               write_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [7:0]                cfg_data,
    input  pcicfg_pkg::back_status_t  back_status,
    input  logic                      q_full,
    output logic                      q_push,
    output pcicfg_pkg::cmd_t          q_cmd
);
    import pcicfg_pkg::*;

    logic [31:0] address_index_reg, address_index_next;
    logic [7:0]  bus_number_reg;
    logic [5:0]  device_count_reg;

    logic        accept;
    logic [3:0]  keep;
    logic [31:0] all_ones;
    logic        size_ok;
    logic        hit;
    logic [4:0]  dev;
    logic [7:0]  base;
    logic [1:0]  bank_pos [NUM_BANKS];
    logic [7:0]  bank_off [NUM_BANKS];
    logic [3:0]  bank_in_range;
    logic [3:0]  byte_ff;
    logic [31:0] idx_rd;
    cmd_t        cmd;

    function automatic logic [1:0] bank_pos_idx(input int b, input logic [1:0] off);
        return 2'(b) - off;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = !back_status.clearing && !q_full;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        keep     = 4'b0001;
        all_ones = 32'h0000_00FF;
        size_ok  = 1'b1;
        case (access_size)
            SIZE_BYTE:
            begin
                keep     = 4'b0001;
                all_ones = 32'h0000_00FF;
                size_ok  = 1'b1;
            end
            SIZE_WORD:
            begin
                keep     = 4'b0011;
                all_ones = 32'h0000_FFFF;
                size_ok  = !port_offset[0];
            end
            SIZE_DWORD:
            begin
                keep     = 4'b1111;
                all_ones = 32'hFFFF_FFFF;
                size_ok  = (port_offset[1:0] == 2'b00);
            end
            default:
            begin
                keep     = 4'b0000;
                all_ones = 32'hFFFF_FFFF;
                size_ok  = 1'b0;
            end
        endcase
    end

    assign dev  = address_index_reg[15:11];
    assign hit  = (address_index_reg[31:24] == HOST_TAG)
               && (address_index_reg[23:16] == bus_number_reg)
               && (address_index_reg[10:8] == 3'd0)
               && ({1'b0, dev} < device_count_reg)
               && ({1'b0, dev} < 6'(MAX_DEVICES));
    assign base = address_index_reg[7:0] + {6'd0, port_offset[1:0]};

    // bank b carries result byte (b - base) of the access
    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bank_pos[b]      = 2'(b) - base[1:0];
            bank_off[b]      = base + {6'd0, bank_pos[b]};
            bank_in_range[b] = ({1'b0, bank_off[b]} < 9'(CONFIG_BYTES));
        end
        for (int i = 0; i < NUM_BANKS; i++)
        begin
            byte_ff[i] = !({1'b0, base + 8'(i)} < 9'(CONFIG_BYTES));
        end
    end

    assign idx_rd = (address_index_reg >> {port_offset[1:0], 3'b000}) & all_ones;

    always_comb
    begin
        address_index_next = address_index_reg;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (keep[bank_pos_idx(b, port_offset[1:0])])
            begin
                address_index_next[b*8 +: 8] =
                    write_data[bank_pos_idx(b, port_offset[1:0])*8 +: 8];
            end
        end
    end

    always_comb
    begin
        cmd       = '0;
        cmd.data  = write_data;
        cmd.dev   = dev;
        cmd.rot   = base[1:0];
        cmd.keep  = keep;
        cmd.ff    = byte_ff;
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            cmd.row[b] = bank_off[b][7:2];
        end
        if (!size_ok)
        begin
            cmd.kind = (op == OP_WRITE) ? CMD_NONE : CMD_DIRECT;
            cmd.data = all_ones;
        end
        else if (!port_offset[2])
        begin
            cmd.kind = (op == OP_WRITE) ? CMD_NONE : CMD_DIRECT;
            cmd.data = idx_rd;
        end
        else if (!hit)
        begin
            cmd.kind = (op == OP_WRITE) ? CMD_NONE : CMD_DIRECT;
            cmd.data = all_ones;
        end
        else
        begin
            cmd.kind = (op == OP_WRITE) ? CMD_WRITE : CMD_READ;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                cmd.bank_en[b] = keep[bank_pos[b]] && bank_in_range[b];
            end
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.kind != CMD_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_index_reg <= '0;
            bus_number_reg    <= '0;
            device_count_reg  <= '0;
        end
        else
        begin
            if (accept && size_ok && !port_offset[2] && (op == OP_WRITE))
            begin
                address_index_reg <= address_index_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BUS_NUMBER:   bus_number_reg   <= cfg_data;
                    CFG_DEVICE_COUNT: device_count_reg <= cfg_data[5:0];
                    default:          bus_number_reg   <= bus_number_reg;
                endcase
            end
        end
    end

endmodule

// ===== design/pcicfg_queue.sv =====
module pcicfg_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pcicfg_pkg::cmd_t  push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output pcicfg_pkg::cmd_t  head
);
    import pcicfg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/pcicfg_back.sv =====
module pcicfg_back #(
    parameter int MAX_DEVICES  = 32,
    parameter int CONFIG_BYTES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  pcicfg_pkg::cmd_t          q_head,
    output logic                      q_pop,
    output pcicfg_pkg::back_status_t  back_status,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [31:0]               read_data
);
    import pcicfg_pkg::*;

    localparam int ROWS  = (CONFIG_BYTES + 3) / 4;
    localparam int DEPTH = MAX_DEVICES * ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    mem [NUM_BANKS][DEPTH];
    logic [7:0]    rd_data_reg [NUM_BANKS];

    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          pend_reg;
    logic [1:0]    pend_rot_reg;
    logic [3:0]    pend_keep_reg;
    logic [3:0]    pend_ff_reg;
    logic          out_valid_reg;
    logic [31:0]   out_data_reg, out_data_next;

    logic          needs_out;
    logic          load;
    logic [AW-1:0] dev_base;
    logic [AW-1:0] bank_addr [NUM_BANKS];
    logic [3:0]    bank_we;
    logic [3:0]    bank_re;
    logic [7:0]    bank_wd [NUM_BANKS];
    logic [31:0]   assembled;

    assign back_status.clearing = clearing_reg;
    assign out_valid            = out_valid_reg;
    assign read_data            = out_data_reg;

    assign needs_out = (q_head.kind == CMD_DIRECT) || (q_head.kind == CMD_READ);
    assign q_pop     = q_valid && !clearing_reg && !pend_reg
                    && (!needs_out || !out_valid_reg || out_ready);
    assign load      = (q_pop && (q_head.kind == CMD_DIRECT)) || pend_reg;

    assign dev_base = AW'(int'(q_head.dev) * ROWS);

    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bank_addr[b] = clearing_reg ? clr_cnt_reg : dev_base + AW'(q_head.row[b]);
            bank_wd[b]   = clearing_reg ? 8'h00
                         : q_head.data[{2'(b) - q_head.rot, 3'b000} +: 8];
            bank_we[b]   = clearing_reg
                        || (q_pop && (q_head.kind == CMD_WRITE) && q_head.bank_en[b]);
            bank_re[b]   = q_pop && (q_head.kind == CMD_READ) && q_head.bank_en[b];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            if (bank_we[b])
            begin
                mem[b][bank_addr[b]] <= bank_wd[b];
            end
            if (bank_re[b])
            begin
                rd_data_reg[b] <= mem[b][bank_addr[b]];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BANKS; i++)
        begin
            if (!pend_keep_reg[i])
            begin
                assembled[i*8 +: 8] = 8'h00;
            end
            else if (pend_ff_reg[i])
            begin
                assembled[i*8 +: 8] = 8'hFF;
            end
            else
            begin
                assembled[i*8 +: 8] = rd_data_reg[pend_rot_reg + 2'(i)];
            end
        end
        out_data_next = pend_reg ? assembled : q_head.data;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pend_rot_reg  <= q_head.rot;
            pend_keep_reg <= q_head.keep;
            pend_ff_reg   <= q_head.ff;
        end
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            pend_reg <= q_pop && (q_head.kind == CMD_READ);
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/pci_config_access_port_unit.sv =====
// PCI configuration mechanism #1 port: an 8-byte window with the address/index
// register at offsets 0-3 and the data window at 4-7. A front stage takes each
// beat, updates or reads the index register and decodes data accesses; a short
// command queue feeds a back stage that owns the configuration store, split
// into four byte banks so any byte, word or dword access (even one that
// straddles a dword) touches each bank at most once. A data-window read
// passes through the registered bank read and then the output register in the
// back stage; a direct result goes straight to the output register, and while
// a result waits only writes can enter the back stage. After reset the store
// is swept to zero, one row per cycle across all banks and through all the
// MAX_DEVICES * ceil(CONFIG_BYTES / 4) rows (2048 at the defaults); in_ready
// stays low for that time, while configuration writes are taken at once.
module pci_config_access_port_unit #(
    parameter int MAX_DEVICES  = 32,
    parameter int CONFIG_BYTES = 256,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [1:0]  access_size,
    input  logic [2:0]  port_offset,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import pcicfg_pkg::*;

    back_status_t back_status;
    cmd_t         push_cmd;
    cmd_t         head_cmd;
    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;

    pcicfg_front #(
        .MAX_DEVICES  (MAX_DEVICES),
        .CONFIG_BYTES (CONFIG_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .access_size (access_size),
        .port_offset (port_offset),
        .write_data  (write_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .back_status (back_status),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    pcicfg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    pcicfg_back #(
        .MAX_DEVICES  (MAX_DEVICES),
        .CONFIG_BYTES (CONFIG_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_head      (head_cmd),
        .q_pop       (q_pop),
        .back_status (back_status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data)
    );

endmodule

// ===== design/pcicfg_checker.sv =====
`include "pci_config_access_port_unit_defines.svh"

module pcicfg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // stalled result beat holds
    `PCICFG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data))

    // result beat only retires through a handshake
    `PCICFG_ASSERT_IMPL(a_out_retire, $fell(out_valid), $past(out_ready))

    // configuration writes never stall
    `PCICFG_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready)

    // store is cleared, so results never carry unknown bits
    `PCICFG_ASSERT_IMPL(a_out_known, out_valid, !$isunknown(read_data))

endmodule

bind pci_config_access_port_unit pcicfg_checker u_pcicfg_checker (.*);

// ===== tb/pci_config_access_port_unit_tb.sv =====
module pci_config_access_port_unit_tb;
    import pcicfg_pkg::*;

    localparam int DEVICES     = 32;
    localparam int REG_BYTES   = 256;
    localparam int IDLE_LIMIT  = 8000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 130;
    localparam int PHASES      = 7;

    localparam logic [1:0] SIZE_BAD = 2'd3;

    typedef struct packed {
        logic        op;
        logic [1:0]  size;
        logic [2:0]  offset;
        logic [31:0] data;
    } access_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        op          = OP_READ;
    logic [1:0]  access_size = SIZE_BYTE;
    logic [2:0]  port_offset = 3'd0;
    logic [31:0] write_data  = 32'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [31:0] read_data;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic        cfg_index   = CFG_BUS_NUMBER;
    logic [7:0]  cfg_data    = 8'd0;

    // predictor state
    logic [31:0] index_reg;
    logic [7:0]  dev_space [DEVICES*REG_BYTES];
    logic [7:0]  bus_sel;
    logic [5:0]  dev_limit;

    access_t     access_queue [$];
    logic [31:0] expected_reads [$];
    int          beats_queued = 0;
    int          beats_in     = 0;
    int          errors       = 0;
    int          hold_reqs    = 0;
    bit          steady       = 1'b0;

    pci_config_access_port_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .access_size (access_size),
        .port_offset (port_offset),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic access_port(input access_t a, output bit has_read, output logic [31:0] rdata);
        int          nb;
        int          i;
        int          dev;
        int          lim;
        int          addr;
        bit          ok;
        bit          hit;
        logic [31:0] ones;
        case (a.size)
            SIZE_BYTE:
            begin
                nb = 1; ones = 32'hFF; ok = 1'b1;
            end
            SIZE_WORD:
            begin
                nb = 2; ones = 32'hFFFF; ok = !a.offset[0];
            end
            SIZE_DWORD:
            begin
                nb = 4; ones = 32'hFFFF_FFFF; ok = (a.offset[1:0] == 2'd0);
            end
            default:
            begin
                nb = 0; ones = 32'hFFFF_FFFF; ok = 1'b0;
            end
        endcase
        has_read = (a.op == OP_READ);
        rdata = ones;
        if (ok && !a.offset[2])
        begin
            if (a.op == OP_WRITE)
            begin
                for (i = 0; i < nb; i++)
                    index_reg[(a.offset + i) * 8 +: 8] = a.data[i * 8 +: 8];
            end
            else
            begin
                rdata = '0;
                for (i = 0; i < nb; i++)
                    rdata[i * 8 +: 8] = index_reg[(a.offset + i) * 8 +: 8];
            end
        end
        else if (ok)
        begin
            lim = (dev_limit > DEVICES) ? DEVICES : int'(dev_limit);
            dev = int'(index_reg[15:11]);
            hit = (index_reg[31:16] == {HOST_TAG, bus_sel}) && (index_reg[10:8] == 3'd0)
                  && (dev < lim);
            if (hit)
            begin
                if (a.op == OP_READ)
                    rdata = '0;
                for (i = 0; i < nb; i++)
                begin
                    addr = dev * REG_BYTES + ((index_reg[7:0] + a.offset - 4 + i) & 8'hFF);
                    if (a.op == OP_WRITE)
                        dev_space[addr] = a.data[i * 8 +: 8];
                    else
                        rdata[i * 8 +: 8] = dev_space[addr];
                end
            end
        end
    endtask

    // sender: bursts with random gaps
    always @(posedge clk)
    begin : sender
        access_t     nxt;
        access_t     cur;
        bit          rd;
        logic [31:0] rv;
        bit          free;
        logic        nv;
        int          burst_left;
        int          gap_left;
        if (rst_n)
        begin
            nv = in_valid;
            free = !in_valid;
            if (in_valid && in_ready)
            begin
                access_port(cur, rd, rv);
                if (rd)
                    expected_reads.push_back(rv);
                beats_in++;
                free = 1'b1;
                nv = 1'b0;
            end
            if (free)
            begin
                if (gap_left > 0 && !steady)
                    gap_left--;
                else if (access_queue.size() > 0)
                begin
                    nxt = access_queue.pop_front();
                    cur = nxt;
                    op <= nxt.op;
                    access_size <= nxt.size;
                    port_offset <= nxt.offset;
                    write_data <= nxt.data;
                    nv = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left--;
                end
            end
            in_valid <= nv;
        end
    end

    // receiver: own stall pattern plus requested long hold-offs
    always @(posedge clk)
    begin : receiver
        logic [31:0] want;
        int          hold_left;
        int          hold_done;
        int          mode_left;
        int          stall_mode;
        int          pat_cnt;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    $error("read_data: beat with nothing expected, expected none, actual %h",
                           read_data);
                    errors++;
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (read_data !== want)
                    begin
                        $error("read_data mismatch: expected %h, actual %h", want, read_data);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_done < hold_reqs)
            begin
                hold_done++;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 256);
                end
                else
                    mode_left--;
                pat_cnt++;
                case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (pat_cnt % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int idle_cnt;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt == IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_beat(input logic o, input logic [1:0] s, input logic [2:0] f,
                              input logic [31:0] d);
        access_t a;
        a.op = o;
        a.size = s;
        a.offset = f;
        a.data = d;
        access_queue.push_back(a);
        beats_queued++;
    endtask

    task automatic set_reg(input logic idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_BUS_NUMBER)
            bus_sel = val;
        else
            dev_limit = val[5:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (beats_in != beats_queued || expected_reads.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // index setup, then a few data beats against it; sometimes plain noise
    task automatic add_sequence(output int cnt);
        logic [31:0] idx;
        logic [1:0]  sz;
        logic [2:0]  off;
        int          lim;
        int          k;
        int          steps;
        int          mode;
        cnt = 0;
        lim = (dev_limit > DEVICES) ? DEVICES : int'(dev_limit);
        if ($urandom_range(0, 9) == 0)
        begin
            queue_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                       3'($urandom_range(0, 7)), $urandom);
            cnt = 1;
        end
        else
        begin
            idx[31:16] = ($urandom_range(0, 7) != 0) ? {HOST_TAG, bus_sel} : 16'($urandom);
            idx[15:11] = ($urandom_range(0, 3) != 0 && lim != 0)
                         ? 5'($urandom_range(0, lim - 1)) : 5'($urandom_range(0, 31));
            idx[10:8] = ($urandom_range(0, 7) != 0) ? 3'd0 : 3'($urandom_range(0, 7));
            idx[7:0] = $urandom_range(0, 1) ? 8'($urandom_range(0, 15) * 4)
                       : 8'($urandom_range(0, 255));
            mode = $urandom_range(0, 9);
            if (mode < 7)
            begin
                queue_beat(OP_WRITE, SIZE_DWORD, 3'd0, idx);
                cnt++;
            end
            else if (mode < 9)
            begin
                queue_beat(OP_WRITE, SIZE_WORD, 3'd0,
                           {16'($urandom_range(0, 65535)), idx[15:0]});
                queue_beat(OP_WRITE, SIZE_WORD, 3'd2,
                           {16'($urandom_range(0, 65535)), idx[31:16]});
                cnt += 2;
            end
            else
            begin
                for (k = 0; k < 4; k++)
                    queue_beat(OP_WRITE, SIZE_BYTE, 3'(k),
                               ($urandom & 32'hFFFF_FF00) | idx[k*8 +: 8]);
                cnt += 4;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                sz = 2'($urandom_range(0, 2));
                off = (sz == SIZE_BYTE) ? 3'($urandom_range(0, 3))
                      : (sz == SIZE_WORD) ? 3'($urandom_range(0, 1) * 2) : 3'd0;
                queue_beat(OP_READ, sz, off, $urandom);
                cnt++;
            end
            steps = $urandom_range(1, 6);
            for (k = 0; k < steps; k++)
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    sz = 2'($urandom_range(0, 2));
                    off = (sz == SIZE_BYTE) ? 3'(4 + $urandom_range(0, 3))
                          : (sz == SIZE_WORD) ? 3'(4 + $urandom_range(0, 1) * 2) : 3'd4;
                end
                else
                begin
                    sz = 2'($urandom_range(0, 3));
                    off = 3'($urandom_range(0, 7));
                end
                queue_beat(1'($urandom_range(0, 1)), sz, off, $urandom);
                cnt++;
            end
        end
    endtask

    initial
    begin : stimulus
        int         i;
        int         p;
        int         n;
        int         got;
        logic [7:0] b;
        logic [7:0] c;
        index_reg = '0;
        bus_sel = 8'd0;
        dev_limit = 6'd0;
        for (i = 0; i < DEVICES * REG_BYTES; i++)
            dev_space[i] = 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: every data access misses
        queue_beat(OP_READ,  SIZE_DWORD, 3'd0, 32'd0);
        queue_beat(OP_READ,  SIZE_DWORD, 3'd4, 32'd0);
        queue_beat(OP_WRITE, SIZE_DWORD, 3'd0, 32'h8000_0004);
        queue_beat(OP_READ,  SIZE_BYTE,  3'd5, 32'd0);
        queue_beat(OP_READ,  SIZE_WORD,  3'd6, 32'd0);
        wait_idle();

        set_reg(CFG_BUS_NUMBER, 8'hA5);
        set_reg(CFG_DEVICE_COUNT, 8'd32);
        queue_beat(OP_WRITE, SIZE_DWORD, 3'd0, 32'h80A5_0010);
        queue_beat(OP_WRITE, SIZE_DWORD, 3'd4, 32'hDEAD_BEEF);
        queue_beat(OP_READ,  SIZE_DWORD, 3'd4, 32'd0);
        queue_beat(OP_READ,  SIZE_BYTE,  3'd5, 32'd0);
        queue_beat(OP_READ,  SIZE_BYTE,  3'd6, 32'd0);
        queue_beat(OP_READ,  SIZE_BYTE,  3'd7, 32'd0);
        queue_beat(OP_READ,  SIZE_WORD,  3'd4, 32'd0);
        queue_beat(OP_READ,  SIZE_WORD,  3'd6, 32'd0);
        queue_beat(OP_WRITE, SIZE_BYTE,  3'd7, 32'hFFFF_FF12);
        queue_beat(OP_READ,  SIZE_DWORD, 3'd4, 32'd0);
        // misaligned and bad sizes
        queue_beat(OP_READ,  SIZE_WORD,  3'd5, 32'd0);
        queue_beat(OP_WRITE, SIZE_WORD,  3'd5, 32'hFFFF_FFFF);
        queue_beat(OP_READ,  SIZE_WORD,  3'd1, 32'd0);
        queue_beat(OP_READ,  SIZE_DWORD, 3'd2, 32'd0);
        queue_beat(OP_WRITE, SIZE_DWORD, 3'd6, 32'd0);
        queue_beat(OP_READ,  SIZE_BAD,   3'd4, 32'd0);
        queue_beat(OP_WRITE, SIZE_BAD,   3'd4, 32'h5555_5555);
        // register offset wraps within the device
        queue_beat(OP_WRITE, SIZE_BYTE,  3'd0, 32'h0000_00FE);
        queue_beat(OP_WRITE, SIZE_DWORD, 3'd4, 32'h0403_0201);
        queue_beat(OP_READ,  SIZE_DWORD, 3'd4, 32'd0);
        // nonzero function, then last device
        queue_beat(OP_WRITE, SIZE_BYTE,  3'd1, 32'h0000_0001);
        queue_beat(OP_READ,  SIZE_DWORD, 3'd4, 32'd0);
        queue_beat(OP_WRITE, SIZE_BYTE,  3'd1, 32'h0000_00F8);
        queue_beat(OP_WRITE, SIZE_DWORD, 3'd4, 32'hFFFF_FFFF);
        queue_beat(OP_READ,  SIZE_BYTE,  3'd4, 32'd0);
        // wrong tag and bus
        queue_beat(OP_WRITE, SIZE_WORD,  3'd2, 32'h0000_0000);
        queue_beat(OP_READ,  SIZE_WORD,  3'd4, 32'd0);
        queue_beat(OP_READ,  SIZE_DWORD, 3'd0, 32'd0);
        wait_idle();

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    b = 8'h5C; c = 8'd32;
                end
                1:
                begin
                    b = 8'hFF; c = 8'd0;
                end
                2:
                begin
                    b = 8'h00; c = 8'd40;
                end
                3:
                begin
                    b = 8'hA5; c = 8'd32;
                end
                4:
                begin
                    b = 8'h37; c = 8'd1;
                end
                5:
                begin
                    b = 8'($urandom_range(0, 255)); c = 8'($urandom_range(0, 32));
                end
                default:
                begin
                    b = 8'h80; c = 8'd31;
                end
            endcase
            set_reg(CFG_BUS_NUMBER, b);
            set_reg(CFG_DEVICE_COUNT, c);
            if (p == 3)
            begin
                steady = 1'b1;
                hold_reqs++;
            end
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                add_sequence(got);
                n += got;
            end
            wait_idle();
            steady = 1'b0;
        end

        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
